// File: rtl/core/samp_pkg.sv
// Shared constants, types and helpers for the smooth approach motion profiler.
package samp_pkg;

    // Fixed-point formats
    localparam int POS_FRAC_BITS = 8;
    localparam int GAIN_FRAC     = 8;
    localparam int TICK_FRAC     = 16;
    localparam int DIR_FRAC      = 20;

    // Datapath widths
    localparam int POS_W   = 32;              // one coordinate
    localparam int MAG_W   = POS_W + 1;       // magnitude of a coordinate difference
    localparam int SUM_W   = 2 * MAG_W;       // sum of three squares, also a full product
    localparam int ROOT_W  = SUM_W / 2;       // integer square root of the sum
    localparam int QUO_W   = DIR_FRAC + 1;    // direction fraction, at most 1.0
    localparam int REM_W   = ROOT_W + 2;      // square root remainder
    localparam int CNT_W   = 6;

    // Iteration counts of the bit-serial unit
    localparam int MUL_ITERS  = MAG_W;
    localparam int DIV_ITERS  = QUO_W;
    localparam int SQRT_ITERS = ROOT_W;

    // Operations of the bit-serial unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } samp_op_t;

    // Request to the bit-serial unit.
    // MUL: a times b[MAG_W-1:0]. DIV: b divided by a. SQRT: root of b.
    typedef struct packed {
        samp_op_t           op;
        logic [MAG_W-1:0]   a;
        logic [SUM_W-1:0]   b;
    } samp_req_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MAX_SPEED,
        REG_DECEL_GAIN,
        REG_ACCEL_GAIN,
        REG_MIN_STEP,
        REG_APPROACH,
        REG_RAMP_ENABLE
    } samp_reg_t;

    // Takes a Q.8 register value to position scale.
    function automatic logic [POS_W-1:0] to_pos(input logic [POS_W-1:0] v);
        logic [POS_W+16-1:0] t;
        t = ({16'b0, v} << POS_FRAC_BITS) >> 8;
        return t[POS_W-1:0];
    endfunction

endpackage

// File: rtl/core/samp_unit.sv
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide and square root.
module samp_unit
    import samp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  samp_req_t        req,
    output logic             done,
    output logic [SUM_W-1:0] result
);

    samp_op_t            op_reg;
    logic [MAG_W-1:0]    a_reg;
    logic [SUM_W-1:0]    p_reg, p_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [MAG_W:0]      mul_sum;
    logic [MAG_W:0]      div_part;
    logic                div_ge;
    logic [MAG_W:0]      div_diff;
    logic [REM_W+1:0]    sq_part;
    logic [REM_W+1:0]    sq_trial;
    logic                sq_ge;
    logic [REM_W+1:0]    sq_diff;

    // One iteration of the selected operation
    always_comb begin
        p_next    = p_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        mul_sum  = {1'b0, p_reg[SUM_W-1:MAG_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

        div_part = {rem_reg[MAG_W-1:0], p_reg[QUO_W-1]};
        div_ge   = div_part >= {1'b0, a_reg};
        div_diff = div_part - {1'b0, a_reg};

        sq_part  = {rem_reg, p_reg[SUM_W-1:SUM_W-2]};
        sq_trial = {1'b0, root_reg, 2'b01};
        sq_ge    = sq_part >= sq_trial;
        sq_diff  = sq_part - sq_trial;

        case (op_reg)
            OP_MUL: begin
                p_next = {mul_sum, p_reg[MAG_W-1:1]};
            end
            OP_DIV: begin
                rem_next = {{(REM_W-MAG_W){1'b0}},
                            (div_ge ? div_diff[MAG_W-1:0] : div_part[MAG_W-1:0])};
                p_next   = {p_reg[SUM_W-1:QUO_W], p_reg[QUO_W-2:0], div_ge};
            end
            OP_SQRT: begin
                rem_next  = sq_ge ? sq_diff[REM_W-1:0] : sq_part[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                p_next    = {p_reg[SUM_W-3:0], 2'b00};
            end
            default: begin
                p_next = p_reg;
            end
        endcase
    end

    // Operand load and iteration count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                a_reg    <= req.a;
                root_reg <= '0;
                case (req.op)
                    OP_MUL: begin
                        cnt_reg <= CNT_W'(MUL_ITERS);
                        p_reg   <= {{(SUM_W-MAG_W){1'b0}}, req.b[MAG_W-1:0]};
                        rem_reg <= '0;
                    end
                    OP_DIV: begin
                        cnt_reg <= CNT_W'(DIV_ITERS);
                        p_reg   <= {{(SUM_W-QUO_W){1'b0}}, req.b[QUO_W-1:0]};
                        rem_reg <= REM_W'(req.b[SUM_W-1:QUO_W]);
                    end
                    OP_SQRT: begin
                        cnt_reg <= CNT_W'(SQRT_ITERS);
                        p_reg   <= req.b;
                        rem_reg <= '0;
                    end
                    default: begin
                        cnt_reg <= CNT_W'(1);
                        p_reg   <= '0;
                        rem_reg <= '0;
                    end
                endcase
            end else if (busy_reg) begin
                p_reg    <= p_next;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Result of the finished operation
    always_comb begin
        case (op_reg)
            OP_MUL:  result = p_reg;
            OP_DIV:  result = {{(SUM_W-QUO_W){1'b0}}, p_reg[QUO_W-1:0]};
            OP_SQRT: result = {{(SUM_W-ROOT_W){1'b0}}, root_reg};
            default: result = p_reg;
        endcase
    end

    assign done = done_reg;

endmodule

// File: rtl/core/smooth_approach_motion_step.sv
// Top level of the three-axis smooth approach motion profiler.
//
// Input stream (s_*): one item per transfer. s_tuser carries the command
// (0 tick, 1 start a move); s_tdata carries target and present position and
// the tick time. Output stream (m_*): one result per input item, with the new
// position, the moving flag and the event flags.
// Write configuration through the APB-style port only while idle; the block does not enforce it.
//
// A move command, or a tick while no move is active, goes straight from decode
// to the result with no arithmetic. A tick during a move runs the full sequence;
// a tick that comes within the minimum step of the target snaps onto it after the
// two square roots, and a tick at zero distance stops after the step product.
// All arithmetic (six squares, two square roots, six products and three divisions)
// runs one result bit per cycle through a single shared bit-serial unit.
// One item is worked on at a time; the next item is taken as soon as the
// previous result sits in the output register, even if the receiver stalls.
// If the output register is still full when a result is ready, the block
// waits until the receiver takes it.
// Reset clears the move state, the output register and loads default
// register values.
module smooth_approach_motion_step
    import samp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,   // target_x, target_y, target_z, cur_x, cur_y, cur_z, tick_time
    input  logic [0:0]   s_tuser,   // cmd
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // new_x, new_y, new_z, moving, ev_start, ev_complete,
                                    // ev_approach, ev_separate, zero fill
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ISSUE,
        ST_WAIT,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        MS_SQ_D0,
        MS_SQ_D1,
        MS_SQ_D2,
        MS_ROOT_D,
        MS_SQ_T0,
        MS_SQ_T1,
        MS_SQ_T2,
        MS_ROOT_T,
        MS_SPEED,
        MS_LIMIT,
        MS_STEP,
        MS_DIV0,
        MS_MUL0,
        MS_DIV1,
        MS_MUL1,
        MS_DIV2,
        MS_MUL2
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg;

    // Configuration registers
    logic [31:0] max_speed_reg;
    logic [15:0] decel_gain_reg;
    logic [15:0] accel_gain_reg;
    logic [15:0] min_step_reg;
    logic [31:0] approach_reg;
    logic        ramp_enable_reg;

    // Latched input item
    logic             cmd_reg;
    logic [POS_W-1:0] tgt_reg [3];
    logic [POS_W-1:0] cur_reg [3];
    logic [15:0]      tick_reg;

    // Move state
    logic [POS_W-1:0] start_reg [3];
    logic [POS_W-1:0] end_reg [3];
    logic             active_reg;
    logic             appr_done_reg;
    logic             sep_done_reg;

    // Working values
    logic [SUM_W-1:0]  sum_reg;
    logic [ROOT_W-1:0] dist_reg;
    logic [ROOT_W-1:0] trav_reg;
    logic [MAG_W-1:0]  speed_reg;
    logic [MAG_W-1:0]  s_reg;
    logic [QUO_W-1:0]  frac_reg;
    logic [POS_W-1:0]  new_reg [3];
    logic              ev_start_reg;
    logic              ev_complete_reg;
    logic              ev_approach_reg;
    logic              ev_separate_reg;

    // Output register
    logic         m_valid_reg;
    logic [103:0] m_data_reg;

    // Unit interface
    logic             unit_start;
    samp_req_t        unit_req;
    logic             unit_done;
    logic [SUM_W-1:0] unit_result;

    logic [1:0]        axis;
    logic              use_trav;
    logic [POS_W-1:0]  op_hi;
    logic [POS_W-1:0]  op_lo;
    logic [MAG_W-1:0]  diff;
    logic              diff_neg;
    logic [MAG_W-1:0]  mag;
    logic [POS_W-1:0]  ms_pos;
    logic [POS_W-1:0]  appr_pos;
    logic [POS_W-1:0]  cap_pos;
    logic [40:0]       scaled;
    logic [MAG_W-1:0]  axis_step;
    logic [POS_W+2:0]  moved;
    logic [POS_W-1:0]  moved_sat;
    logic              last_step;

    assign ms_pos   = to_pos({16'b0, min_step_reg});
    assign appr_pos = to_pos(approach_reg);
    assign cap_pos  = to_pos(max_speed_reg);

    // Axis and difference that the current micro-step works on
    always_comb begin
        case (step_reg)
            MS_SQ_D0, MS_SQ_T0, MS_DIV0, MS_MUL0: axis = 2'd0;
            MS_SQ_D1, MS_SQ_T1, MS_DIV1, MS_MUL1: axis = 2'd1;
            MS_SQ_D2, MS_SQ_T2, MS_DIV2, MS_MUL2: axis = 2'd2;
            default:                              axis = 2'd0;
        endcase
        use_trav = (step_reg == MS_SQ_T0) || (step_reg == MS_SQ_T1) ||
                   (step_reg == MS_SQ_T2);
        op_hi    = use_trav ? cur_reg[axis] : end_reg[axis];
        op_lo    = use_trav ? start_reg[axis] : cur_reg[axis];
        diff     = {op_hi[POS_W-1], op_hi} - {op_lo[POS_W-1], op_lo};
        diff_neg = diff[MAG_W-1];
        mag      = diff_neg ? (~diff + MAG_W'(1)) : diff;
    end

    // Request for the current micro-step
    always_comb begin
        unit_req.op = OP_MUL;
        unit_req.a  = mag;
        unit_req.b  = {{(SUM_W-MAG_W){1'b0}}, mag};
        case (step_reg)
            MS_ROOT_D, MS_ROOT_T: begin
                unit_req.op = OP_SQRT;
                unit_req.a  = '0;
                unit_req.b  = sum_reg;
            end
            MS_SPEED: begin
                unit_req.a = MAG_W'(dist_reg);
                unit_req.b = SUM_W'(decel_gain_reg);
            end
            MS_LIMIT: begin
                unit_req.a = MAG_W'(trav_reg);
                unit_req.b = SUM_W'(accel_gain_reg);
            end
            MS_STEP: begin
                unit_req.a = speed_reg;
                unit_req.b = SUM_W'(tick_reg);
            end
            MS_DIV0, MS_DIV1, MS_DIV2: begin
                unit_req.op = OP_DIV;
                unit_req.a  = MAG_W'(dist_reg);
                unit_req.b  = SUM_W'({mag, {DIR_FRAC{1'b0}}});
            end
            MS_MUL0, MS_MUL1, MS_MUL2: begin
                unit_req.a = MAG_W'(frac_reg);
                unit_req.b = SUM_W'(s_reg);
            end
            default: begin
                unit_req.op = OP_MUL;
            end
        endcase
    end

    assign unit_start = (state_reg == ST_ISSUE);

    samp_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .req     (unit_req),
        .done    (unit_done),
        .result  (unit_result)
    );

    // Result shaping for the captured product
    assign scaled    = unit_result[48:8];
    assign axis_step = unit_result[DIR_FRAC+MAG_W-1:DIR_FRAC];
    assign moved     = diff_neg
                     ? ({{3{cur_reg[axis][POS_W-1]}}, cur_reg[axis]} - {2'b00, axis_step})
                     : ({{3{cur_reg[axis][POS_W-1]}}, cur_reg[axis]} + {2'b00, axis_step});

    // Saturate the moved coordinate to the signed position range
    always_comb begin
        if (moved[POS_W+2:POS_W-1] == '0 || moved[POS_W+2:POS_W-1] == '1) begin
            moved_sat = moved[POS_W-1:0];
        end else if (moved[POS_W+2]) begin
            moved_sat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            moved_sat = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    assign last_step = (step_reg == MS_MUL2) ||
                       (step_reg == MS_STEP && dist_reg == '0);

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (cmd_reg || !active_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (unit_done) begin
                    if (step_reg == MS_ROOT_T) begin
                        state_next = ST_DECIDE;
                    end else if (last_step) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_DECIDE: begin
                if (MAG_W'(dist_reg) < MAG_W'(ms_pos)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer, move state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= MS_SQ_D0;
            active_reg    <= 1'b0;
            appr_done_reg <= 1'b0;
            sep_done_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;

            // A new result loaded in the done state replaces the taken one.
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg  <= s_tuser[0];
                        tick_reg <= s_tdata[207:192];
                        for (int i = 0; i < 3; i++) begin
                            tgt_reg[i] <= s_tdata[i*POS_W +: POS_W];
                            cur_reg[i] <= s_tdata[(i+3)*POS_W +: POS_W];
                        end
                    end
                end
                ST_DECODE: begin
                    ev_start_reg    <= cmd_reg;
                    ev_complete_reg <= 1'b0;
                    ev_approach_reg <= 1'b0;
                    ev_separate_reg <= 1'b0;
                    step_reg        <= MS_SQ_D0;
                    for (int i = 0; i < 3; i++) begin
                        new_reg[i] <= cur_reg[i];
                    end
                    if (cmd_reg) begin
                        active_reg    <= 1'b1;
                        appr_done_reg <= 1'b0;
                        sep_done_reg  <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            start_reg[i] <= cur_reg[i];
                            end_reg[i]   <= tgt_reg[i];
                        end
                    end
                end
                ST_WAIT: begin
                    if (unit_done) begin
                        step_reg <= step_t'(5'(step_reg) + 5'd1);
                        case (step_reg)
                            MS_SQ_D0, MS_SQ_T0: sum_reg <= unit_result;
                            MS_SQ_D1, MS_SQ_D2, MS_SQ_T1, MS_SQ_T2: begin
                                sum_reg <= sum_reg + unit_result;
                            end
                            MS_ROOT_D: dist_reg <= unit_result[ROOT_W-1:0];
                            MS_ROOT_T: trav_reg <= unit_result[ROOT_W-1:0];
                            MS_SPEED: begin
                                if (scaled > 41'(cap_pos)) begin
                                    speed_reg <= MAG_W'(cap_pos);
                                end else begin
                                    speed_reg <= scaled[MAG_W-1:0];
                                end
                            end
                            MS_LIMIT: begin
                                if (ramp_enable_reg && 41'(speed_reg) > scaled) begin
                                    speed_reg <= MAG_W'(scaled[POS_W-1:0]) + MAG_W'(ms_pos);
                                end
                            end
                            MS_STEP: s_reg <= unit_result[TICK_FRAC+MAG_W-1:TICK_FRAC];
                            MS_DIV0, MS_DIV1, MS_DIV2: frac_reg <= unit_result[QUO_W-1:0];
                            MS_MUL0, MS_MUL1, MS_MUL2: new_reg[axis] <= moved_sat;
                            default: begin
                                sum_reg <= sum_reg;
                            end
                        endcase
                    end
                end
                ST_DECIDE: begin
                    if (MAG_W'(dist_reg) < MAG_W'(ms_pos)) begin
                        active_reg      <= 1'b0;
                        ev_complete_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            new_reg[i] <= end_reg[i];
                        end
                    end else begin
                        step_reg <= MS_SPEED;
                        if (!appr_done_reg && MAG_W'(dist_reg) <= MAG_W'(appr_pos)) begin
                            appr_done_reg   <= 1'b1;
                            ev_approach_reg <= 1'b1;
                        end
                        if (!sep_done_reg && MAG_W'(trav_reg) >= MAG_W'(appr_pos)) begin
                            sep_done_reg    <= 1'b1;
                            ev_separate_reg <= 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'b000, ev_separate_reg, ev_approach_reg,
                                        ev_complete_reg, ev_start_reg, active_reg,
                                        new_reg[2], new_reg[1], new_reg[0]};
                    end
                end
                default: begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg   <= 32'd25600;
            decel_gain_reg  <= 16'd256;
            accel_gain_reg  <= 16'd256;
            min_step_reg    <= 16'd256;
            approach_reg    <= 32'd25600;
            ramp_enable_reg <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (samp_reg_t'(paddr[4:2]))
                REG_MAX_SPEED:   max_speed_reg   <= pwdata;
                REG_DECEL_GAIN:  decel_gain_reg  <= pwdata[15:0];
                REG_ACCEL_GAIN:  accel_gain_reg  <= pwdata[15:0];
                REG_MIN_STEP:    min_step_reg    <= pwdata[15:0];
                REG_APPROACH:    approach_reg    <= pwdata;
                REG_RAMP_ENABLE: ramp_enable_reg <= pwdata[0];
                default: begin
                    ramp_enable_reg <= ramp_enable_reg;
                end
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        case (samp_reg_t'(paddr[4:2]))
            REG_MAX_SPEED:   prdata = max_speed_reg;
            REG_DECEL_GAIN:  prdata = {16'b0, decel_gain_reg};
            REG_ACCEL_GAIN:  prdata = {16'b0, accel_gain_reg};
            REG_MIN_STEP:    prdata = {16'b0, min_step_reg};
            REG_APPROACH:    prdata = approach_reg;
            REG_RAMP_ENABLE: prdata = {31'b0, ramp_enable_reg};
            default:         prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
